[design/slc_pkg.sv]
// shared constants and types for the source line classifier
`default_nettype none

package slc_pkg;

    // counter width; result fields carry the low 32 bits
    localparam int COUNT_WIDTH = 32;
    localparam int FIELD_WIDTH = 32;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // leading characters of the current line
    localparam logic [1:0] LEAD_NONE  = 2'd0;
    localparam logic [1:0] LEAD_SLASH = 2'd1;
    localparam logic [1:0] LEAD_TWO   = 2'd2;
    localparam logic [1:0] LEAD_OTHER = 2'd3;

    // kind of the previous byte, for mark detection
    localparam logic [1:0] PREV_OTHER = 2'd0;
    localparam logic [1:0] PREV_SLASH = 2'd1;
    localparam logic [1:0] PREV_STAR  = 2'd2;

    // byte codes
    localparam logic [7:0] CHR_NL    = 8'h0A;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_STAR  = 8'h2A;

    // action codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_EOF  = 1'b1;

    // saturating increment
    function automatic count_t sat_inc(input count_t v);
        count_t r;
        r = (&v) ? v : v + count_t'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

[design/source_line_classifier_core.sv]
// top level of the source line classifier: byte stream in, running line totals out
`default_nettype none

// Source line classifier. Feed the bytes of a C source file, one item per
// byte with tuser low, then one item with tuser high to end the file. Every
// item returns exactly one result item holding the running code, comment and
// blank line totals and the count of finished files, plus a flag in tuser
// that says whether this item closed and classified a line (a newline byte,
// or end of file while a partial line is pending). Lines are split at 0x0A;
// spaces and tabs alone make a blank line, carriage return is non-blank.
// Block comments carry across lines and are dropped at end of file. All
// totals saturate. The block takes one item per cycle: an input register
// feeds one level of classification logic that writes the state and result
// registers, so an item is held in the input register and then in the result
// register, and back-to-back items run at full rate as long as the result
// side keeps tready high. A stalled result holds the input side after one
// buffered item.
module source_line_classifier_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] text_byte
    input  wire logic [0:0]   s_tuser,   // [0] action (1 = end of file)
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // [31:0] code_count, [63:32] comment_count,
                                         // [95:64] blank_count, [127:96] files_done
    output logic [0:0]        m_tuser    // [0] line_closed
);

    // input register
    logic       in_valid_reg;
    logic       action_reg;
    logic [7:0] byte_reg;

    // line and comment state
    logic       in_block_reg,    in_block_next;
    logic       line_pending_reg, line_pending_next;
    logic       line_nonblank_reg, line_nonblank_next;
    logic [1:0] lead_reg,        lead_next;
    logic [1:0] prev_reg,        prev_next;
    logic       saw_open_reg,    saw_open_next;
    logic       saw_close_reg,   saw_close_next;

    // totals double as the result register
    slc_pkg::count_t code_total_reg,    code_total_next;
    slc_pkg::count_t comment_total_reg, comment_total_next;
    slc_pkg::count_t blank_total_reg,   blank_total_next;
    slc_pkg::count_t file_total_reg,    file_total_next;
    logic            line_closed_reg,   line_closed_next;
    logic            out_valid_reg;

    logic advance;
    logic is_eof;
    logic is_nl;
    logic classify;
    logic blank_byte;

    // stage moves when an item is buffered and the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign is_eof     = (action_reg == slc_pkg::ACT_EOF);
    assign is_nl      = !is_eof && (byte_reg == slc_pkg::CHR_NL);
    assign classify   = is_nl || (is_eof && line_pending_reg);
    assign blank_byte = byte_reg inside {slc_pkg::CHR_SPACE, slc_pkg::CHR_TAB};

    always_comb
    begin
        in_block_next      = in_block_reg;
        line_pending_next  = line_pending_reg;
        line_nonblank_next = line_nonblank_reg;
        lead_next          = lead_reg;
        prev_next          = prev_reg;
        saw_open_next      = saw_open_reg;
        saw_close_next     = saw_close_reg;
        code_total_next    = code_total_reg;
        comment_total_next = comment_total_reg;
        blank_total_next   = blank_total_reg;
        file_total_next    = file_total_reg;
        line_closed_next   = classify;

        // classify the finished line, first matching rule wins
        if (classify)
        begin
            if (!line_nonblank_reg)
            begin
                blank_total_next = slc_pkg::sat_inc(blank_total_reg);
            end
            else if (in_block_reg)
            begin
                comment_total_next = slc_pkg::sat_inc(comment_total_reg);
                if (saw_close_reg)
                begin
                    in_block_next = 1'b0;
                end
            end
            else if (lead_reg == slc_pkg::LEAD_TWO)
            begin
                comment_total_next = slc_pkg::sat_inc(comment_total_reg);
            end
            else if (saw_open_reg)
            begin
                comment_total_next = slc_pkg::sat_inc(comment_total_reg);
                if (!saw_close_reg)
                begin
                    in_block_next = 1'b1;
                end
            end
            else
            begin
                code_total_next = slc_pkg::sat_inc(code_total_reg);
            end
        end

        if (is_eof || is_nl)
        begin
            // line state starts over
            line_pending_next  = 1'b0;
            line_nonblank_next = 1'b0;
            lead_next          = slc_pkg::LEAD_NONE;
            prev_next          = slc_pkg::PREV_OTHER;
            saw_open_next      = 1'b0;
            saw_close_next     = 1'b0;
            if (is_eof)
            begin
                in_block_next   = 1'b0;
                file_total_next = slc_pkg::sat_inc(file_total_reg);
            end
        end
        else
        begin
            line_pending_next = 1'b1;
            if (!blank_byte)
            begin
                line_nonblank_next = 1'b1;
            end
            // track whether the line opens with two slashes
            if (lead_reg == slc_pkg::LEAD_SLASH)
            begin
                lead_next = (byte_reg == slc_pkg::CHR_SLASH) ? slc_pkg::LEAD_TWO
                                                             : slc_pkg::LEAD_OTHER;
            end
            else if (lead_reg == slc_pkg::LEAD_NONE && !blank_byte)
            begin
                lead_next = (byte_reg == slc_pkg::CHR_SLASH) ? slc_pkg::LEAD_SLASH
                                                             : slc_pkg::LEAD_OTHER;
            end
            // open and close marks anywhere in the line, overlap allowed
            case (byte_reg)
                slc_pkg::CHR_SLASH:
                begin
                    if (prev_reg == slc_pkg::PREV_STAR)
                    begin
                        saw_close_next = 1'b1;
                    end
                    prev_next = slc_pkg::PREV_SLASH;
                end
                slc_pkg::CHR_STAR:
                begin
                    if (prev_reg == slc_pkg::PREV_SLASH)
                    begin
                        saw_open_next = 1'b1;
                    end
                    prev_next = slc_pkg::PREV_STAR;
                end
                default:
                begin
                    prev_next = slc_pkg::PREV_OTHER;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            action_reg <= s_tuser[0];
            byte_reg   <= s_tdata;
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_block_reg      <= 1'b0;
            line_pending_reg  <= 1'b0;
            line_nonblank_reg <= 1'b0;
            lead_reg          <= slc_pkg::LEAD_NONE;
            prev_reg          <= slc_pkg::PREV_OTHER;
            saw_open_reg      <= 1'b0;
            saw_close_reg     <= 1'b0;
            code_total_reg    <= '0;
            comment_total_reg <= '0;
            blank_total_reg   <= '0;
            file_total_reg    <= '0;
            line_closed_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                in_block_reg      <= in_block_next;
                line_pending_reg  <= line_pending_next;
                line_nonblank_reg <= line_nonblank_next;
                lead_reg          <= lead_next;
                prev_reg          <= prev_next;
                saw_open_reg      <= saw_open_next;
                saw_close_reg     <= saw_close_next;
                code_total_reg    <= code_total_next;
                comment_total_reg <= comment_total_next;
                blank_total_reg   <= blank_total_next;
                file_total_reg    <= file_total_next;
                line_closed_reg   <= line_closed_next;
                out_valid_reg     <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {slc_pkg::FIELD_WIDTH'(file_total_reg),
                       slc_pkg::FIELD_WIDTH'(blank_total_reg),
                       slc_pkg::FIELD_WIDTH'(comment_total_reg),
                       slc_pkg::FIELD_WIDTH'(code_total_reg)};
    assign m_tuser  = line_closed_reg;

`ifndef SYNTH
    // end of file leaves no open comment and no pending line
    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_eof |=> !in_block_reg && !line_pending_reg)
        else $error("end of file did not clear line state");

    // end of file bumps the file count unless saturated
    a_eof_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_eof |=> (file_total_reg == $past(file_total_reg) + 1'b1)
                              || (&$past(file_total_reg)))
        else $error("file count did not advance");

    // at most one line total moves per item
    a_one_class: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> $countones({code_total_reg != $past(code_total_reg),
                                comment_total_reg != $past(comment_total_reg),
                                blank_total_reg != $past(blank_total_reg)}) <= 1)
        else $error("more than one line class counted");

    // a closed line leaves no pending partial line
    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        line_closed_reg |-> !line_pending_reg && !saw_open_reg && !saw_close_reg)
        else $error("line state kept after close");
`endif

endmodule

`default_nettype wire

[verif/source_line_classifier_checker.sv]
// checker for the source line classifier: predicts running line totals and compares results
`timescale 1ns / 100ps

module source_line_classifier_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] text_byte
    input  wire logic [0:0]   s_tuser,   // [0] action
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [127:0] m_tdata,   // [31:0] code, [63:32] comment, [95:64] blank,
                                         // [127:96] files_done
    input  wire logic [0:0]   m_tuser,   // [0] line_closed
    output int                mismatch_count,
    output int                pending_results
);

    typedef struct packed {
        logic [slc_pkg::FIELD_WIDTH-1:0] files;
        logic [slc_pkg::FIELD_WIDTH-1:0] blank;
        logic [slc_pkg::FIELD_WIDTH-1:0] comment;
        logic [slc_pkg::FIELD_WIDTH-1:0] code;
        logic                            closed;
    } line_totals_t;

    line_totals_t expected_totals[$];

    // predicted classifier state
    logic            block_open;
    logic            line_started;
    logic            line_has_text;
    logic [1:0]      lead;
    logic [1:0]      prev_char;
    logic            seen_open;
    logic            seen_close;
    slc_pkg::count_t code_tally;
    slc_pkg::count_t comment_tally;
    slc_pkg::count_t blank_tally;
    slc_pkg::count_t files_seen;

    function automatic slc_pkg::count_t bump(input slc_pkg::count_t v);
        return (v == '1) ? v : v + slc_pkg::count_t'(1);
    endfunction

    task automatic clear_line_state();
        line_started  = 1'b0;
        line_has_text = 1'b0;
        lead          = slc_pkg::LEAD_NONE;
        prev_char     = slc_pkg::PREV_OTHER;
        seen_open     = 1'b0;
        seen_close    = 1'b0;
    endtask

    task automatic close_line();
        if (!line_has_text)
            blank_tally = bump(blank_tally);
        else if (block_open)
        begin
            comment_tally = bump(comment_tally);
            if (seen_close)
                block_open = 1'b0;
        end
        else if (lead == slc_pkg::LEAD_TWO)
            comment_tally = bump(comment_tally);
        else if (seen_open)
        begin
            comment_tally = bump(comment_tally);
            if (!seen_close)
                block_open = 1'b1;
        end
        else
            code_tally = bump(code_tally);
        clear_line_state();
    endtask

    task automatic take_char(input logic [7:0] b);
        logic is_blank;
        is_blank = (b == slc_pkg::CHR_SPACE) || (b == slc_pkg::CHR_TAB);
        line_started = 1'b1;
        if (lead == slc_pkg::LEAD_SLASH)
            lead = (b == slc_pkg::CHR_SLASH) ? slc_pkg::LEAD_TWO : slc_pkg::LEAD_OTHER;
        else if (lead == slc_pkg::LEAD_NONE && !is_blank)
            lead = (b == slc_pkg::CHR_SLASH) ? slc_pkg::LEAD_SLASH : slc_pkg::LEAD_OTHER;
        if (!is_blank)
            line_has_text = 1'b1;
        if (b == slc_pkg::CHR_SLASH)
        begin
            if (prev_char == slc_pkg::PREV_STAR)
                seen_close = 1'b1;
            prev_char = slc_pkg::PREV_SLASH;
        end
        else if (b == slc_pkg::CHR_STAR)
        begin
            if (prev_char == slc_pkg::PREV_SLASH)
                seen_open = 1'b1;
            prev_char = slc_pkg::PREV_STAR;
        end
        else
            prev_char = slc_pkg::PREV_OTHER;
    endtask

    // one accepted item in, one expected result out
    task automatic classify_item(input logic act, input logic [7:0] b);
        line_totals_t t;
        t.closed = 1'b0;
        if (act == slc_pkg::ACT_EOF)
        begin
            if (line_started)
            begin
                close_line();
                t.closed = 1'b1;
            end
            clear_line_state();
            block_open = 1'b0;
            files_seen = bump(files_seen);
        end
        else if (b == slc_pkg::CHR_NL)
        begin
            close_line();
            t.closed = 1'b1;
        end
        else
            take_char(b);
        t.code    = code_tally[slc_pkg::FIELD_WIDTH-1:0];
        t.comment = comment_tally[slc_pkg::FIELD_WIDTH-1:0];
        t.blank   = blank_tally[slc_pkg::FIELD_WIDTH-1:0];
        t.files   = files_seen[slc_pkg::FIELD_WIDTH-1:0];
        expected_totals.push_back(t);
    endtask

    task automatic check_result();
        line_totals_t want;
        line_totals_t got;
        logic         bad;
        got = {m_tdata, m_tuser[0]};
        if (expected_totals.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result: code %0d comment %0d blank %0d files %0d closed %0b",
                         got.code, got.comment, got.blank, got.files, got.closed);
        end
        else
        begin
            want = expected_totals.pop_front();
            bad  = (got.code !== want.code) || (got.comment !== want.comment)
                || (got.blank !== want.blank) || (got.files !== want.files)
                || (got.closed !== want.closed);
            if (bad)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected: code %0d comment %0d blank %0d files %0d closed %0b",
                             want.code, want.comment, want.blank, want.files, want.closed);
                    $display("  actual:   code %0d comment %0d blank %0d files %0d closed %0b",
                             got.code, got.comment, got.blank, got.files, got.closed);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            block_open     = 1'b0;
            clear_line_state();
            code_tally     = '0;
            comment_tally  = '0;
            blank_tally    = '0;
            files_seen     = '0;
            mismatch_count = 0;
            expected_totals.delete();
        end
        else
        begin
            // a result never belongs to an item accepted at the same edge
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                classify_item(s_tuser[0], s_tdata);
        end
        pending_results = expected_totals.size();
    end

endmodule

[verif/source_line_classifier_core_tb.sv]
// testbench top for the source line classifier: stimulus, idling and verdict
`timescale 1ns / 100ps

module source_line_classifier_core_tb;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int LONG_STALL   = 300;

    // idling modes, one per phase
    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = '0;
    logic [0:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;

    int mismatch_count;
    int pending_results;
    int idle_mode    = IDLE_NONE;
    int items_sent   = 0;
    int stall_reqs   = 0;
    int cycle_count  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    source_line_classifier_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    source_line_classifier_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // whole-run watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL source_line_classifier_core");
        $finish;
    end

    function automatic logic sender_idles();
        if (idle_mode == IDLE_SENDER)
            return $urandom_range(0, 99) < 49;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 6;
        return 1'b0;
    endfunction

    function automatic logic receiver_stalls();
        if (idle_mode == IDLE_RECEIVER)
            return $urandom_range(0, 99) < 49;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 6;
        return 1'b0;
    endfunction

    // result side: random stalls plus a long hold-off when one is requested
    initial
    begin : result_side
        int stall_left;
        int stall_seen;
        stall_left = 0;
        stall_seen = 0;
        forever
        begin
            @(negedge clk);
            if (stall_reqs != stall_seen)
            begin
                stall_seen = stall_reqs;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= rst_n && !receiver_stalls();
        end
    end

    // offer one item; valid stays high across back-to-back items
    task automatic send_item(input logic act, input logic [7:0] b);
        @(negedge clk);
        while (sender_idles())
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 1'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_item(slc_pkg::ACT_BYTE, txt[i]);
    endtask

    task automatic send_eof();
        // the byte field is don't-care on end of file
        send_item(slc_pkg::ACT_EOF, 8'($urandom));
    endtask

    // a line built from comment marks, blanks and ordinary characters
    task automatic send_random_line();
        int         n_tokens;
        logic [7:0] b;
        n_tokens = $urandom_range(0, 10);
        for (int i = 0; i < n_tokens; i++)
        begin
            case ($urandom_range(0, 11))
                0:  send_item(slc_pkg::ACT_BYTE, slc_pkg::CHR_SPACE);
                1:  send_item(slc_pkg::ACT_BYTE, slc_pkg::CHR_TAB);
                2:  send_text("//");
                3:  send_text("/*");
                4:  send_text("*/");
                5:  send_item(slc_pkg::ACT_BYTE, slc_pkg::CHR_SLASH);
                6:  send_item(slc_pkg::ACT_BYTE, slc_pkg::CHR_STAR);
                7:  send_item(slc_pkg::ACT_BYTE, 8'h0D);
                8,
                9:  send_item(slc_pkg::ACT_BYTE, 8'($urandom_range(8'h21, 8'h7E)));
                10:
                begin
                    b = 8'($urandom);
                    send_item(slc_pkg::ACT_BYTE, (b == slc_pkg::CHR_NL) ? 8'hFF : b);
                end
                default: send_text("/*/");
            endcase
        end
        // sometimes the file ends in the middle of a line
        if ($urandom_range(0, 11) == 0)
            send_eof();
        else
            send_item(slc_pkg::ACT_BYTE, slc_pkg::CHR_NL);
    endtask

    task automatic send_noise();
        send_item(1'($urandom_range(0, 3) == 0), 8'($urandom));
    endtask

    initial
    begin : stimulus
        int target;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        send_text("\n");           // newline on an empty line
        send_text("//\n");         // two-slash comment
        send_text("/ \n");         // slash then space is code
        send_text("/*/\n");        // overlapping open and close marks
        send_text("/*\n");         // opens a block comment
        send_text("*/\n");         // closed inside the block
        send_item(slc_pkg::ACT_BYTE, 8'hFF);
        send_item(slc_pkg::ACT_BYTE, 8'h00);
        send_item(slc_pkg::ACT_BYTE, 8'h0D);   // carriage return is non-blank
        send_text("\n");
        send_text("/");            // lone slash at end of file
        send_eof();
        send_text(" \t");          // partial line of blanks only
        send_eof();
        send_text("/*");           // block opened by the last partial line
        send_eof();
        send_eof();                // end of file with no partial line
        send_text("x\n");          // block must not survive the file end

        // random part, one idling mode per phase
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_mode = phase;
            target    = items_sent + RANDOM_ITEMS / 4;
            // hold the result side off while items keep coming
            if (phase == IDLE_NONE)
                stall_reqs++;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    send_random_line();
                if ($urandom_range(0, 19) == 0)
                    send_eof();
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        idle_mode = IDLE_NONE;
        while (pending_results != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS source_line_classifier_core");
        else
            $display("FAIL source_line_classifier_core");
        $finish;
    end

endmodule
